/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands (clk / rst_n domain).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on clk with the reset disable built in.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on clk that also holds during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int CFG_BITS = 6;

    typedef struct packed {
        logic ins;      // new sample enters this cycle
        logic del;      // oldest sample leaves this cycle
        logic restart;  // window emptied before the insert
    } swm_ctrl_t;

endpackage

/* src/sliding_window_median_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running lower median over the last window_size signed samples.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------
//   s_axis   | in  | tdata: sample ; tuser: restart
//   m_axis   | out | tdata: median (zero padded to bytes)
//   cfg      | in  | cfg_wdata: window_size
//
// One request per cycle when the output keeps up; a median is registered
// by the cell chain update, then by the output register.
// After window_size shrinks below the fill, the oldest surplus samples
// are dropped before new requests are taken.
// Reset empties the chain and sets window_size to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_median_top #(
    parameter int WINDOW_MAX  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // [sample]
    input  logic                                s_axis_tuser,   // [restart]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // [median]
    input  logic                                cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]        cfg_wdata
);

    localparam int DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int IDX_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SLOT_BITS = $clog2(WINDOW_MAX + 2);

    logic [swm_pkg::CFG_BITS-1:0]  window_size_reg;
    logic [CNT_BITS-1:0]           fill_reg, fill_next;
    logic                          pend_reg, pend_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_data_reg, m_data_next;

    logic [CNT_BITS-1:0]           k_eff;
    logic [CNT_BITS-1:0]           fill_less;
    logic [CNT_BITS-1:0]           k_less;
    logic [CNT_BITS-1:0]           new_fill;
    logic [IDX_BITS-1:0]           mid;
    logic [SLOT_BITS-1:0]          mid_slot;
    logic                          drop;
    logic                          can_move;
    logic                          ins;
    logic                          del_en;
    logic signed [SAMPLE_BITS-1:0] sample;
    swm_pkg::swm_ctrl_t            ctrl;

    logic signed [SAMPLE_BITS-1:0] cv   [0:WINDOW_MAX+1];
    logic        [IDX_BITS-1:0]    ca   [0:WINDOW_MAX+1];
    logic                          ck   [0:WINDOW_MAX+1];
    logic                          cg   [0:WINDOW_MAX+1];
    logic                          ds   [0:WINDOW_MAX+1];

    always_comb
    begin
        if (window_size_reg == '0)
            k_eff = CNT_BITS'(1);
        else if (32'(window_size_reg) > WINDOW_MAX)
            k_eff = CNT_BITS'(WINDOW_MAX);
        else
            k_eff = CNT_BITS'(window_size_reg);
    end

    assign sample        = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign drop          = fill_reg > k_eff;
    assign can_move      = ~m_valid_reg | m_axis_tready;
    assign s_axis_tready = ~drop & (~pend_reg | can_move);
    assign ins           = s_axis_tvalid & s_axis_tready;
    assign del_en        = drop | (ins & ~s_axis_tuser & (fill_reg == k_eff));
    assign fill_less     = fill_reg - CNT_BITS'(1);
    assign k_less        = k_eff - CNT_BITS'(1);
    assign mid           = IDX_BITS'(k_less >> 1);
    assign mid_slot      = SLOT_BITS'(mid) + SLOT_BITS'(1);

    assign ctrl.ins     = ins;
    assign ctrl.del     = del_en;
    assign ctrl.restart = ins & s_axis_tuser;

    always_comb
    begin
        if (ctrl.restart)
            new_fill = CNT_BITS'(1);
        else
            new_fill = fill_reg - CNT_BITS'(del_en) + CNT_BITS'(ins);
    end

    // chain ends
    assign cv[0]            = '0;
    assign ca[0]            = '0;
    assign ck[0]            = 1'b0;
    assign cg[0]            = 1'b0;
    assign ds[0]            = 1'b0;
    assign ds[1]            = 1'b0;
    assign cv[WINDOW_MAX+1] = '0;
    assign ca[WINDOW_MAX+1] = '0;
    assign ck[WINDOW_MAX+1] = 1'b0;
    assign cg[WINDOW_MAX+1] = 1'b0;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        if (i < WINDOW_MAX - 1)
        begin : g_link
            swm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_BITS    (IDX_BITS),
                .CNT_BITS    (CNT_BITS),
                .IDX         (i)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .sample       (sample),
                .del_age      (fill_less[IDX_BITS-1:0]),
                .new_fill     (new_fill),
                .del_seen_in  (ds[i+1]),
                .del_seen_out (ds[i+2]),
                .lo_val       (cv[i]),
                .lo_age       (ca[i]),
                .lo_kept      (ck[i]),
                .lo_gt        (cg[i]),
                .lo_del_seen  (ds[i]),
                .hi_val       (cv[i+2]),
                .hi_age       (ca[i+2]),
                .hi_kept      (ck[i+2]),
                .hi_gt        (cg[i+2]),
                .val          (cv[i+1]),
                .age          (ca[i+1]),
                .kept         (ck[i+1]),
                .gt           (cg[i+1])
            );
        end
        else
        begin : g_last
            logic ds_end;
            swm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_BITS    (IDX_BITS),
                .CNT_BITS    (CNT_BITS),
                .IDX         (i)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .sample       (sample),
                .del_age      (fill_less[IDX_BITS-1:0]),
                .new_fill     (new_fill),
                .del_seen_in  (ds[i+1]),
                .del_seen_out (ds_end),
                .lo_val       (cv[i]),
                .lo_age       (ca[i]),
                .lo_kept      (ck[i]),
                .lo_gt        (cg[i]),
                .lo_del_seen  (ds[i]),
                .hi_val       (cv[i+2]),
                .hi_age       (ca[i+2]),
                .hi_kept      (ck[i+2]),
                .hi_gt        (cg[i+2]),
                .val          (cv[i+1]),
                .age          (ca[i+1]),
                .kept         (ck[i+1]),
                .gt           (cg[i+1])
            );
            assign ds[i+2] = ds_end;
        end
    end

    always_comb
    begin
        fill_next    = fill_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ins | del_en)
            fill_next = new_fill;
        if (can_move)
        begin
            m_valid_next = pend_reg;
            m_data_next  = cv[mid_slot];
            pend_next    = 1'b0;
        end
        if (ins)
            pend_next = (new_fill == k_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::CFG_BITS'(1);
            fill_reg        <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                window_size_reg <= cfg_wdata;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'($unsigned(m_data_reg));

    `ASSERT_CLK(a_fill_bound, fill_reg <= CNT_BITS'(WINDOW_MAX),
        "fill count beyond chain length")
    `ASSERT_CLK(a_no_accept_over, ins |-> fill_reg <= k_eff,
        "request accepted while surplus samples remain")
    `ASSERT_CLK(a_pend_holds, (pend_reg && !can_move) |=> pend_reg,
        "pending median lost under output stall")
    `ASSERT_CLK(a_restart_fill, (ins && s_axis_tuser) |=> fill_reg == CNT_BITS'(1),
        "restart did not leave a single sample")

endmodule

/* src/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: value, age and valid. Per update it keeps
// its value, takes its neighbor's, or takes the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_BITS    = 5,
    parameter int CNT_BITS    = 6,
    parameter int IDX         = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::swm_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [AGE_BITS-1:0]    del_age,
    input  logic        [CNT_BITS-1:0]    new_fill,
    input  logic                          del_seen_in,
    output logic                          del_seen_out,
    input  logic signed [SAMPLE_BITS-1:0] lo_val,
    input  logic        [AGE_BITS-1:0]    lo_age,
    input  logic                          lo_kept,
    input  logic                          lo_gt,
    input  logic                          lo_del_seen,
    input  logic signed [SAMPLE_BITS-1:0] hi_val,
    input  logic        [AGE_BITS-1:0]    hi_age,
    input  logic                          hi_kept,
    input  logic                          hi_gt,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic        [AGE_BITS-1:0]    age,
    output logic                          kept,
    output logic                          gt
);

    logic                          valid_reg, valid_next;
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic        [AGE_BITS-1:0]    age_reg, age_next;
    logic                          step;
    logic                          del_me;
    logic                          from_hi;
    logic                          from_lo;
    logic                          stay;
    logic                          in_range;
    logic        [AGE_BITS-1:0]    age_inc;

    assign step         = ctrl.ins | ctrl.del;
    assign del_me       = valid_reg & ctrl.del & (age_reg == del_age);
    assign kept         = valid_reg & ~ctrl.restart & ~del_me;
    assign gt           = kept & ctrl.ins & (val_reg > sample);
    assign del_seen_out = del_seen_in | del_me;
    assign from_hi      = hi_kept & del_seen_out & ~hi_gt;
    assign from_lo      = lo_kept & ~lo_del_seen & lo_gt;
    assign stay         = kept & (del_seen_in == gt);
    assign in_range     = CNT_BITS'(IDX) < new_fill;
    assign age_inc      = AGE_BITS'(ctrl.ins);
    assign val          = val_reg;
    assign age          = age_reg;

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        age_next   = age_reg;
        if (step)
        begin
            valid_next = in_range;
            if (from_hi)
            begin
                val_next = hi_val;
                age_next = hi_age + age_inc;
            end
            else if (from_lo)
            begin
                val_next = lo_val;
                age_next = lo_age + age_inc;
            end
            else if (stay)
            begin
                age_next = age_reg + age_inc;
            end
            else
            begin
                val_next = sample;
                age_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

/* sim/tb_sliding_window_median_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_top
// Self-checking bench for the running lower-median filter.
//
// A queue of sample requests feeds a stream driver. Each accepted request
// updates a local copy of the window, in arrival order and sorted, and
// queues the expected median once the window is full. A monitor checks
// each output median against the oldest expected one. window_size is
// changed between phases while the filter is drained, covering sizes 0,
// 1, 32 and above 32, plus shrink and grow with a filled window. Both
// stream sides idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_top;

    typedef logic signed [15:0] sample_t;

    typedef struct {
        sample_t sample;
        logic    restart;
    } median_req_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [15:0]                  s_axis_tdata = '0;   // [sample]
    logic                         s_axis_tuser = 1'b0; // [restart]
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [15:0]                  m_axis_tdata;        // [median]
    logic                         cfg_we = 1'b0;
    logic [swm_pkg::CFG_BITS-1:0] cfg_wdata = '0;

    median_req_t req_pending[$];
    sample_t     median_expected[$];

    // local window copy
    sample_t                      win_hist[32];
    sample_t                      win_sorted[32];
    int unsigned                  win_fill = 0;
    int unsigned                  win_oldest = 0;
    logic [swm_pkg::CFG_BITS-1:0] win_size = 6'd1;

    int unsigned mismatch_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_hold = 0;
    int unsigned long_stall_seq = 0;
    int unsigned long_stall_seen = 0;
    bit          no_idle = 1'b0;

    sliding_window_median_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic median_predict(input sample_t v, input logic restart);
        int unsigned k;
        int unsigned i;
        int unsigned pos;
        sample_t     old;
        k = (win_size == 0) ? 1 : (win_size > 32) ? 32 : win_size;
        if (restart)
        begin
            win_fill   = 0;
            win_oldest = 0;
        end
        while (win_fill >= k)
        begin
            old = win_hist[win_oldest];
            pos = 0;
            while (pos + 1 < win_fill && win_sorted[pos] != old)
                pos++;
            for (i = pos; i + 1 < win_fill; i++)
                win_sorted[i] = win_sorted[i + 1];
            win_oldest = (win_oldest + 1) % 32;
            win_fill--;
        end
        win_hist[(win_oldest + win_fill) % 32] = v;
        i = win_fill;
        while (i > 0 && win_sorted[i - 1] > v)
        begin
            win_sorted[i] = win_sorted[i - 1];
            i--;
        end
        win_sorted[i] = v;
        win_fill++;
        if (win_fill == k)
            median_expected = {median_expected, win_sorted[(k + 1) / 2 - 1]};
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        median_req_t req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                median_predict(sample_t'(s_axis_tdata), s_axis_tuser);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 && !no_idle)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (req_pending.size() > 0 && (no_idle || $urandom_range(0, 9) != 0))
                begin
                    req = req_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= req.sample;
                    s_axis_tuser  <= req.restart;
                end
                else
                begin
                    if (req_pending.size() > 0)
                        send_gap = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // median monitor
    always @(posedge clk or negedge rst_n)
    begin
        sample_t exp_median;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (median_expected.size() == 0)
                begin
                    $error("median: unexpected result %0d", $signed(m_axis_tdata));
                    mismatch_count++;
                end
                else
                begin
                    exp_median = median_expected.pop_front();
                    if (m_axis_tdata !== exp_median)
                    begin
                        $error("median: expected %0d, got %0d", exp_median,
                               $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                end
            end
            if (long_stall_seen != long_stall_seq)
            begin
                long_stall_seen = long_stall_seq;
                recv_hold = 299;
                m_axis_tready <= 1'b0;
            end
            else if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                recv_hold = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_sample(input sample_t v, input logic restart);
        median_req_t req;
        req.sample  = v;
        req.restart = restart;
        req_pending = {req_pending, req};
    endtask

    task automatic queue_random(input int n, input int restart_odds);
        sample_t v;
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: v = 16'sh7FFF;
                1: v = 16'sh8000;
                2: v = sample_t'($urandom_range(0, 6)) - 16'sd3;
                default: v = sample_t'($urandom);
            endcase
            queue_sample(v, $urandom_range(0, restart_odds - 1) == 0);
        end
    endtask

    // wait until every request is taken and every median has arrived
    task automatic drain();
        do
            @(negedge clk);
        while (req_pending.size() != 0 || s_axis_tvalid || median_expected.size() != 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic reconfigure(input logic [swm_pkg::CFG_BITS-1:0] size);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        win_size = size;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // window of one (reset value): extremes, restart
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b1);

        // size zero acts as one
        reconfigure(6'd0);
        queue_sample(-16'sd5, 1'b0);
        queue_sample(16'sd9, 1'b1);

        // equal samples and restart during fill
        reconfigure(6'd3);
        queue_sample(16'sd4, 1'b1);
        queue_sample(16'sd4, 1'b0);
        queue_sample(16'sd4, 1'b0);
        queue_sample(-16'sd2, 1'b0);
        queue_sample(16'sd4, 1'b0);
        queue_sample(16'sd100, 1'b1);
        queue_sample(16'sd7, 1'b0);
        queue_sample(16'sd7, 1'b0);

        // fill five, then shrink while filled, then grow
        reconfigure(6'd5);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sd3, 1'b0);
        queue_sample(-16'sd3, 1'b0);
        queue_sample(16'sd0, 1'b0);
        reconfigure(6'd2);
        queue_sample(16'sd11, 1'b0);
        queue_sample(-16'sd11, 1'b0);
        reconfigure(6'd4);
        queue_sample(16'sd20, 1'b0);
        queue_sample(16'sd21, 1'b0);
        queue_sample(16'sd22, 1'b0);

        // full-size window, with a long output stall
        reconfigure(6'd32);
        long_stall_seq++;
        queue_random(60, 80);

        reconfigure(6'd63);
        queue_random(45, 60);
        reconfigure(6'd1);
        queue_random(25, 4);
        reconfigure(6'd33);
        queue_random(40, 80);
        reconfigure(6'd0);
        queue_random(15, 3);

        // mid-phase pause until all medians are in
        reconfigure(6'd7);
        queue_random(20, 15);
        drain();
        queue_random(20, 15);

        reconfigure(6'd16);
        queue_random(35, 30);
        repeat (4)
        begin
            reconfigure(6'($urandom_range(1, 32)));
            queue_random(20, 20);
        end

        // last phase: no idling on either side
        reconfigure(6'd32);
        no_idle = 1'b1;
        queue_random(60, 100);
        drain();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median_top.sv
sim/tb_sliding_window_median_top.sv
